// ----- hdl/linear_probe_hash_table_assert.svh -----
// assertion macros for the hash table
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LPHT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpht check failed");
`define LPHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpht check failed");
`endif

// ----- hdl/lpht_pkg.sv -----
`default_nettype none
package lpht_pkg;
  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_LIVE = 2'd1;
  localparam logic [1:0] TAG_TOMB = 2'd2;
  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
  localparam logic [9:0] LOAD_LIMIT_RESET = 10'd768;
  localparam logic [1:0] REG_LOAD_LIMIT = 2'd0;

  typedef struct packed {
    logic [1:0] operation;
    logic [63:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [63:0] read_value;
    logic [10:0] live_entries;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic hash_step;
    logic hash_home;
    logic rd;
    logic advance;
    logic wr_tag;
    logic [1:0] tag_val;
    logic wr_kd;
    logic use_tomb;
    logic live_inc;
    logic live_dec;
    logic tomb_inc;
    logic tomb_dec;
    logic set_rsp;
    logic [1:0] rsp_status;
    logic rsp_data;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hash_done;
    logic [1:0] tag;
    logic key_eq;
    logic last;
    logic have_tomb;
    logic below_limit;
    logic [1:0] op;
  } sts_t;
endpackage
`default_nettype wire

// ----- hdl/linear_probe_hash_table.sv -----
// Hash table of SLOTS entries with linear probing. After reset a clearing pass empties every
// slot tag; no request is taken meanwhile. Each request runs the FNV-1a hash (per byte an xor
// step and a multiply step, the prime product done as a shift and a small constant product),
// then a read step and a check step per probed slot for the registered memory read, and an
// output step that waits until the output register is free. The next request can be taken
// in the same cycle as the result first shows in the output register. One request is handled
// at a time.
`default_nettype none
module linear_probe_hash_table #(
  parameter int SLOTS = 1024,
  parameter int KEY_BITS = 64,
  parameter int VALUE_BITS = 64
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire lpht_pkg::req_t in_data,
  output logic out_valid,
  input wire logic out_stall,
  output lpht_pkg::rsp_t out_data,
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic [1:0] paddr,
  input wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import lpht_pkg::*;
  `include "linear_probe_hash_table_assert.svh"

  localparam logic [1:0] LIMIT_ADDR = 2'(32'(REG_LOAD_LIMIT) << 2);

  logic [9:0] load_limit;
  cmd_t cmd;
  sts_t sts;
  logic clr_done;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= LOAD_LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == LIMIT_ADDR) begin
      load_limit <= pwdata[9:0];
    end
  end
  assign prdata = (paddr == LIMIT_ADDR) ? {22'd0, load_limit} : 32'd0;

  lpht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .clr_done(clr_done), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );
  lpht_dp #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst(rst), .req(in_data), .load_limit(load_limit), .cmd(cmd), .sts(sts),
    .clr_done(clr_done), .rsp(out_data)
  );

  `LPHT_ASSERT_IMPL(a_no_accept_busy, cmd.load, !in_stall)
  `LPHT_ASSERT_IMPL(a_single_write, cmd.wr_tag, !cmd.load)
  `LPHT_ASSERT_NEXT(a_rsp_valid, cmd.set_rsp, out_valid)
endmodule
`default_nettype wire

// ----- hdl/lpht_ram.sv -----
`default_nettype none
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/lpht_ctrl.sv -----
`default_nettype none
module lpht_ctrl (
  input wire logic clk,
  input wire logic rst,
  input wire logic clr_done,
  input wire logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input wire logic out_stall,
  output lpht_pkg::cmd_t cmd,
  input wire lpht_pkg::sts_t sts
);
  import lpht_pkg::*;
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state, state_next;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.set_rsp) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        if (clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_done) begin
          cmd.hash_home = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.op != OP_SET && sts.op != OP_GET && sts.op != OP_DEL) begin
          state_next = S_OUT;
          cmd.rsp_status = ST_MISS;
        end else if (sts.tag == TAG_LIVE && sts.key_eq) begin
          state_next = S_OUT;
          if (sts.op == OP_SET) begin
            cmd.wr_kd = 1'b1;
          end else if (sts.op == OP_GET) begin
            cmd.rsp_data = 1'b1;
          end else begin
            cmd.wr_tag = 1'b1;
            cmd.tag_val = TAG_TOMB;
            cmd.live_dec = 1'b1;
            cmd.tomb_inc = 1'b1;
          end
        end else if (sts.tag == TAG_EMPTY || sts.last) begin
          state_next = S_OUT;
          if (sts.op != OP_SET) begin
            cmd.rsp_status = ST_MISS;
          end else if (sts.have_tomb) begin
            cmd.use_tomb = 1'b1;
            cmd.wr_tag = 1'b1;
            cmd.tag_val = TAG_LIVE;
            cmd.wr_kd = 1'b1;
            cmd.live_inc = 1'b1;
            cmd.tomb_dec = 1'b1;
          end else if (sts.tag == TAG_TOMB) begin
            // only tombstone met is the last slot probed
            cmd.wr_tag = 1'b1;
            cmd.tag_val = TAG_LIVE;
            cmd.wr_kd = 1'b1;
            cmd.live_inc = 1'b1;
            cmd.tomb_dec = 1'b1;
          end else if (sts.tag == TAG_EMPTY && sts.below_limit) begin
            cmd.wr_tag = 1'b1;
            cmd.tag_val = TAG_LIVE;
            cmd.wr_kd = 1'b1;
            cmd.live_inc = 1'b1;
          end else begin
            cmd.rsp_status = ST_FULL;
          end
        end else begin
          cmd.advance = 1'b1;
          state_next = S_READ;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.set_rsp = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- hdl/lpht_dp.sv -----
`default_nettype none
module lpht_dp #(
  parameter int SLOTS = 1024,
  parameter int KEY_BITS = 64,
  parameter int VALUE_BITS = 64
) (
  input wire logic clk,
  input wire logic rst,
  input wire lpht_pkg::req_t req,
  input wire logic [9:0] load_limit,
  input wire lpht_pkg::cmd_t cmd,
  output lpht_pkg::sts_t sts,
  output logic clr_done,
  output lpht_pkg::rsp_t rsp
);
  import lpht_pkg::*;
  localparam int AW = $clog2(SLOTS);
  localparam int CW = AW + 1;

  logic [1:0] op;
  logic [KEY_BITS-1:0] key;
  logic [VALUE_BITS-1:0] value;
  logic [63:0] hash, prod;
  logic [3:0] hstep;
  logic [AW-1:0] idx, tomb_idx;
  logic [CW-1:0] count, live_total, tomb_total;
  logic have_tomb;
  logic clearing;
  logic [AW-1:0] clr_addr;
  logic [1:0] tag_q, pend_tag;
  logic [KEY_BITS-1:0] key_q;
  logic [VALUE_BITS-1:0] data_q;
  logic [1:0] status_r;
  logic [63:0] rd_r;
  logic [7:0] byte_sel;
  logic [11:0] sum;

  // each byte takes an xor step, then a multiply step
  assign byte_sel = 8'((64'(key) >> {hstep[3:1], 3'b000}));
  // prime is 2^40 + 0x1b3: shift plus a small constant product
  assign prod = (hash << 40) + (hash * 64'(FNV_PRIME[8:0]));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req.operation;
      key <= req.key[KEY_BITS-1:0];
      value <= req.value[VALUE_BITS-1:0];
      hash <= FNV_BASIS;
      hstep <= '0;
      have_tomb <= 1'b0;
      count <= '0;
    end else if (cmd.hash_step) begin
      hstep <= hstep + 4'd1;
      if (!hstep[0]) begin
        hash <= hash ^ 64'(byte_sel);
      end else begin
        hash <= prod;
      end
    end
    if (cmd.hash_home) begin
      idx <= prod[AW-1:0];
    end
    if (cmd.advance) begin
      idx <= idx + AW'(1);
      count <= count + CW'(1);
      if (tag_q == TAG_TOMB && !have_tomb) begin
        have_tomb <= 1'b1;
        tomb_idx <= idx;
      end
    end
  end

  assign sts.hash_done = (hstep == 4'd15);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      live_total <= '0;
      tomb_total <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(SLOTS - 1)) begin
          clearing <= 1'b0;
        end
      end
      live_total <= live_total + CW'(cmd.live_inc) - CW'(cmd.live_dec);
      tomb_total <= tomb_total + CW'(cmd.tomb_inc) - CW'(cmd.tomb_dec);
    end
  end
  assign clr_done = !clearing;

  logic [AW-1:0] waddr;
  logic tag_we;
  logic [1:0] tag_wd;
  assign waddr = cmd.use_tomb ? tomb_idx : idx;
  assign tag_we = clearing || cmd.wr_tag;
  assign tag_wd = clearing ? TAG_EMPTY : cmd.tag_val;

  lpht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_tag (
    .clk(clk), .we(tag_we), .waddr(clearing ? clr_addr : waddr), .wdata(tag_wd),
    .raddr(idx), .rdata(tag_q)
  );
  lpht_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key (
    .clk(clk), .we(cmd.wr_kd), .waddr(waddr), .wdata(key),
    .raddr(idx), .rdata(key_q)
  );
  lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_data (
    .clk(clk), .we(cmd.wr_kd), .waddr(waddr), .wdata(value),
    .raddr(idx), .rdata(data_q)
  );

  assign pend_tag = tag_q;
  assign sum = 12'(live_total) + 12'(tomb_total);
  assign sts.tag = pend_tag;
  assign sts.key_eq = (key_q == key);
  assign sts.last = (count == CW'(SLOTS - 1));
  assign sts.have_tomb = have_tomb;
  assign sts.below_limit = sum < 12'(load_limit);
  assign sts.op = op;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      status_r <= ST_OK;
      rd_r <= '0;
    end
    if (cmd.rsp_status != ST_OK) begin
      status_r <= cmd.rsp_status;
    end
    if (cmd.rsp_data) begin
      rd_r <= 64'(data_q);
    end
    if (cmd.set_rsp) begin
      rsp.status <= status_r;
      rsp.read_value <= rd_r;
      rsp.live_entries <= 11'(live_total);
    end
  end
endmodule
`default_nettype wire
